// File: hw/rtl/binary_edge_curve_tracer_defines.svh
// Assertion macros shared by the tracer RTL.
`ifndef BINARY_EDGE_CURVE_TRACER_DEFINES_SVH
`define BINARY_EDGE_CURVE_TRACER_DEFINES_SVH

// Generic clocked assertion with asynchronous active-low reset.
`define BECT_ASSERT(lbl, ck, rst_n, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) else $error(msg);

// Same, on the block clock and reset.
`define BECT_ASSERT_CLK(lbl, prop, msg) \
	`BECT_ASSERT(lbl, clk, arst_n, prop, msg)

`endif

// File: hw/rtl/bect_pkg.sv
package bect_pkg;

	localparam int DEF_MAX_ROWS = 256;
	localparam int DEF_MAX_COLS = 256;
	localparam int DEF_MAX_GAP  = 7;

	localparam int CFG_W       = 9;
	localparam int IDX_W       = 2;
	localparam int LEN_DIVISOR = 25;
	localparam int CLOSE_LIMIT = 31; // squared-distance stand-in for 5.656

	localparam logic [IDX_W-1:0] REG_ROWS = 2'd0;
	localparam logic [IDX_W-1:0] REG_COLS = 2'd1;
	localparam logic [IDX_W-1:0] REG_GAP  = 2'd2;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_PULL = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_PULL,
		ST_FIND,
		ST_FIND_CHK,
		ST_WIN_INIT,
		ST_WIN_RD,
		ST_WIN_CHK,
		ST_WIN_END,
		ST_PHASE_END,
		ST_KEEP,
		ST_RD_PT,
		ST_OUT,
		ST_OUT_DONE
	} state_t;

endpackage

// File: hw/rtl/bect_ram.sv
module bect_ram #(
	parameter int AW = 16,
	parameter int DW = 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hw/rtl/binary_edge_curve_tracer.sv
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tuser: kind; tdata[0]: pixel
// m_*       out  m_tvalid/m_tready  tdata: pos_x, pos_y, curve_number, closed_loop;
//                                   tlast: last_of_curve; tuser: done_res
// cfg_*     in   cfg_we             cfg_index, cfg_wdata
//
// Load words are taken back to back. A pull of a point already traced runs ST_PULL,
// ST_RD_PT and ST_OUT; ST_OUT loads its result word. A pull that starts a new curve
// scans cells for a start pixel in ST_FIND and ST_FIND_CHK, then reads each traced
// point's window in ST_WIN_RD and ST_WIN_CHK: one edge-map port, one cell a step.
// A register write holds s_tready low in its own cycle and through ST_DIV (bit-serial
// divide to place the load pointer). Reset clears control state; the maps need no
// clearing. A result waits in the output register; the next word is still taken meanwhile.
`include "binary_edge_curve_tracer_defines.svh"

module binary_edge_curve_tracer #(
	parameter int MAX_ROWS = bect_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = bect_pkg::DEF_MAX_COLS,
	parameter int MAX_GAP  = bect_pkg::DEF_MAX_GAP
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [bect_pkg::IDX_W-1:0] cfg_index,
	input  logic [bect_pkg::CFG_W-1:0] cfg_wdata,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [7:0]                 s_tdata,  // [0] pixel
	input  logic                       s_tuser,  // [0] kind
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [39:0]                m_tdata,  // [7:0] pos_x, [15:8] pos_y,
	                                             // [31:16] curve_number, [32] closed_loop
	output logic                       m_tlast,  // last_of_curve
	output logic                       m_tuser   // [0] done_res
);
	import bect_pkg::*;

	localparam int RW       = $clog2(MAX_ROWS);
	localparam int CW       = $clog2(MAX_COLS);
	localparam int AW       = RW + CW;
	localparam int PW       = AW + 1;
	localparam int GW       = $clog2(MAX_GAP + 1);
	localparam int DW       = $clog2(2 * MAX_GAP * MAX_GAP + 1);
	localparam int IW       = $clog2(PW + 1);
	localparam int MAP_SIZE = MAX_ROWS * MAX_COLS;
	// image size in use straight after reset (256 by 256, clamped)
	localparam int RST_ROWS = (MAX_ROWS < 256) ? MAX_ROWS : 256;
	localparam int RST_COLS = (MAX_COLS < 256) ? MAX_COLS : 256;

	state_t st_q, st_d;

	// configuration
	logic [CFG_W-1:0] rows_q, cols_q;
	logic [2:0]       gap_q;
	logic [RW:0]      rows_e;
	logic [CW:0]      cols_e;
	logic [GW-1:0]    gap_e;
	logic [PW-1:0]    total_q;
	logic             cfg_wr;

	// load pointer and start scan pointer
	logic [PW-1:0] load_pos_q;
	logic [RW:0]   load_r_q;
	logic [CW-1:0] load_c_q;
	logic [PW-1:0] scan_p_q;
	logic [RW-1:0] scan_r_q;
	logic [CW-1:0] scan_c_q;

	// bit-serial divider: load_pos / cols
	logic [IW-1:0] div_i_q;
	logic [PW-1:0] div_q_q;
	logic [CW-1:0] div_rem_q;
	logic [CW:0]   div_sh;
	logic          div_ge;

	// trace state
	logic [AW-1:0] start_q, cur_q, best_q, first_q, last_q, bidx_q, base_q;
	logic [PW-1:0] cnt_q;
	logic          fwd_q, bv_q;
	logic [DW-1:0] best_d_q, d_w;
	logic [RW-1:0] yy_q, yhi_q;
	logic [CW-1:0] xx_q, xlo_q, xhi_q;
	logic [RW-1:0] ylo_w, yhi_w;
	logic [CW-1:0] xlo_w, xhi_w;
	logic          keep_w, closed_w;

	// curve read-out
	logic [PW-1:0] rd_pos_q, curve_len_q;
	logic [15:0]   curve_count_q;
	logic          closed_q;

	// output register
	logic          m_valid_q;
	logic [7:0]    out_x_q, out_y_q;
	logic [15:0]   out_num_q;
	logic          out_last_q, out_closed_q, out_done_q;
	logic          out_free;
	logic          out_load;

	// memories
	logic          map_we, map_wdata, map_re, map_rdata;
	logic [AW-1:0] map_waddr, map_raddr;
	logic          cp_we, cp_re;
	logic [AW-1:0] cp_waddr, cp_wdata, cp_raddr, cp_rdata;

	logic acc;

	bect_ram #(.AW(AW), .DW(1)) u_map (
		.clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
		.re(map_re), .raddr(map_raddr), .rdata(map_rdata)
	);

	bect_ram #(.AW(AW), .DW(AW)) u_pts (
		.clk(clk), .we(cp_we), .waddr(cp_waddr), .wdata(cp_wdata),
		.re(cp_re), .raddr(cp_raddr), .rdata(cp_rdata)
	);

	// effective sizes, clamped to the supported range
	always_comb begin
		if (rows_q == '0) rows_e = (RW+1)'(1);
		else if (int'(rows_q) > MAX_ROWS) rows_e = (RW+1)'(MAX_ROWS);
		else rows_e = (RW+1)'(rows_q);
		if (cols_q == '0) cols_e = (CW+1)'(1);
		else if (int'(cols_q) > MAX_COLS) cols_e = (CW+1)'(MAX_COLS);
		else cols_e = (CW+1)'(cols_q);
		if (gap_q == '0) gap_e = GW'(1);
		else if (int'(gap_q) > MAX_GAP) gap_e = GW'(MAX_GAP);
		else gap_e = GW'(gap_q);
	end

	assign cfg_wr   = cfg_we && (cfg_index == REG_ROWS || cfg_index == REG_COLS ||
		cfg_index == REG_GAP);
	assign s_tready = (st_q == ST_IDLE) && !cfg_we;
	assign acc      = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	// a point or done word enters the output register
	assign out_load = (st_q == ST_OUT || st_q == ST_OUT_DONE) && out_free && !cfg_wr;

	assign div_sh = {div_rem_q, div_q_q[PW-1]};
	assign div_ge = div_sh >= cols_e;

	// window bounds, candidate distance, keep and closure tests
	always_comb begin
		int ylo, yhi, xlo, xhi, dy, dx, fdy, fdx;
		ylo = int'(cur_q[AW-1:CW]) - int'(gap_e);
		yhi = int'(cur_q[AW-1:CW]) + int'(gap_e);
		xlo = int'(cur_q[CW-1:0]) - int'(gap_e);
		xhi = int'(cur_q[CW-1:0]) + int'(gap_e);
		if (ylo < 0) ylo = 0;
		if (xlo < 0) xlo = 0;
		if (yhi > int'(rows_e) - 1) yhi = int'(rows_e) - 1;
		if (xhi > int'(cols_e) - 1) xhi = int'(cols_e) - 1;
		ylo_w = RW'(ylo);
		yhi_w = RW'(yhi);
		xlo_w = CW'(xlo);
		xhi_w = CW'(xhi);
		dy = int'(yy_q) - int'(cur_q[AW-1:CW]);
		dx = int'(xx_q) - int'(cur_q[CW-1:0]);
		d_w = DW'(dy * dy + dx * dx);
		fdy = int'(first_q[AW-1:CW]) - int'(last_q[AW-1:CW]);
		fdx = int'(first_q[CW-1:0]) - int'(last_q[CW-1:0]);
		closed_w = (fdy * fdy + fdx * fdx) <= CLOSE_LIMIT;
		keep_w = (LEN_DIVISOR * int'(cnt_q)) > (int'(rows_e) + int'(cols_e));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// next state and memory strobes
	always_comb begin
		st_d      = st_q;
		map_we    = 1'b0;
		map_waddr = {load_r_q[RW-1:0], load_c_q};
		map_wdata = 1'b0;
		map_re    = 1'b0;
		map_raddr = {scan_r_q, scan_c_q};
		cp_we     = 1'b0;
		cp_waddr  = '0;
		cp_wdata  = {scan_r_q, scan_c_q};
		cp_re     = 1'b0;
		cp_raddr  = base_q + rd_pos_q[AW-1:0];
		unique case (st_q)
			ST_IDLE: begin
				if (acc) begin
					if (s_tuser == KIND_LOAD) begin
						if (load_pos_q < total_q) begin
							map_we    = 1'b1;
							map_wdata = s_tdata[0];
						end
					end else begin
						st_d = ST_PULL;
					end
				end
			end
			ST_DIV: begin
				if (div_i_q == '0) st_d = ST_IDLE;
			end
			ST_PULL: begin
				st_d = (rd_pos_q < curve_len_q) ? ST_RD_PT : ST_FIND;
			end
			ST_FIND: begin
				if (scan_p_q >= total_q) begin
					st_d = ST_OUT_DONE;
				end else begin
					map_re = 1'b1;
					st_d   = ST_FIND_CHK;
				end
			end
			ST_FIND_CHK: begin
				if (map_rdata) begin
					map_we    = 1'b1;
					map_waddr = {scan_r_q, scan_c_q};
					cp_we     = 1'b1;
					st_d      = ST_WIN_INIT;
				end else begin
					st_d = ST_FIND;
				end
			end
			ST_WIN_INIT: begin
				st_d = (cnt_q == PW'(MAP_SIZE)) ? ST_PHASE_END : ST_WIN_RD;
			end
			ST_WIN_RD: begin
				map_re    = 1'b1;
				map_raddr = {yy_q, xx_q};
				st_d      = ST_WIN_CHK;
			end
			ST_WIN_CHK: begin
				st_d = (xx_q == xhi_q && yy_q == yhi_q) ? ST_WIN_END : ST_WIN_RD;
			end
			ST_WIN_END: begin
				if (bv_q) begin
					map_we    = 1'b1;
					map_waddr = best_q;
					cp_we     = 1'b1;
					cp_waddr  = fwd_q ? cnt_q[AW-1:0] : bidx_q;
					cp_wdata  = best_q;
					st_d      = ST_WIN_INIT;
				end else begin
					st_d = ST_PHASE_END;
				end
			end
			ST_PHASE_END: begin
				st_d = fwd_q ? ST_WIN_INIT : ST_KEEP;
			end
			ST_KEEP: begin
				st_d = keep_w ? ST_RD_PT : ST_FIND;
			end
			ST_RD_PT: begin
				cp_re = 1'b1;
				st_d  = ST_OUT;
			end
			ST_OUT, ST_OUT_DONE: begin
				if (out_free) st_d = ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
		if (cfg_wr) st_d = ST_DIV;
	end

	// datapath and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q        <= CFG_W'(256);
			cols_q        <= CFG_W'(256);
			gap_q         <= 3'd1;
			total_q       <= PW'(RST_ROWS * RST_COLS);
			load_pos_q    <= '0;
			load_r_q      <= '0;
			load_c_q      <= '0;
			scan_p_q      <= '0;
			scan_r_q      <= '0;
			scan_c_q      <= '0;
			div_i_q       <= '0;
			div_q_q       <= '0;
			div_rem_q     <= '0;
			cnt_q         <= '0;
			fwd_q         <= 1'b0;
			bv_q          <= 1'b0;
			bidx_q        <= '1;
			rd_pos_q      <= '0;
			curve_len_q   <= '0;
			curve_count_q <= '0;
			closed_q      <= 1'b0;
			m_valid_q     <= 1'b0;
		end else begin
			total_q <= PW'(int'(rows_e) * int'(cols_e));
			if (out_load) m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;

			// register write: new sizes, restart start scan, re-place load pointer
			if (cfg_wr) begin
				unique case (cfg_index)
					REG_ROWS: rows_q <= cfg_wdata;
					REG_COLS: cols_q <= cfg_wdata;
					default:  gap_q  <= cfg_wdata[2:0];
				endcase
				scan_p_q  <= '0;
				scan_r_q  <= '0;
				scan_c_q  <= '0;
				div_i_q   <= IW'(PW);
				div_q_q   <= load_pos_q;
				div_rem_q <= '0;
			end else begin
				unique case (st_q)
					ST_IDLE: begin
						if (acc && s_tuser == KIND_LOAD && load_pos_q < total_q) begin
							if (s_tdata[0] && load_pos_q < scan_p_q) begin
								scan_p_q <= load_pos_q;
								scan_r_q <= load_r_q[RW-1:0];
								scan_c_q <= load_c_q;
							end
							load_pos_q <= load_pos_q + PW'(1);
							if ({1'b0, load_c_q} + (CW+1)'(1) == cols_e) begin
								load_c_q <= '0;
								load_r_q <= load_r_q + (RW+1)'(1);
							end else begin
								load_c_q <= load_c_q + CW'(1);
							end
						end
					end
					ST_DIV: begin
						if (div_i_q == '0) begin
							load_r_q <= (RW+1)'(div_q_q);
							load_c_q <= div_rem_q;
						end else begin
							div_rem_q <= div_ge ? CW'(div_sh - cols_e) : div_sh[CW-1:0];
							div_q_q   <= {div_q_q[PW-2:0], div_ge};
							div_i_q   <= div_i_q - IW'(1);
						end
					end
					ST_FIND: begin
						if (scan_p_q >= total_q) begin
							rd_pos_q    <= '0;
							curve_len_q <= '0;
						end
					end
					ST_FIND_CHK: begin
						if (map_rdata) begin
							start_q <= {scan_r_q, scan_c_q};
							cur_q   <= {scan_r_q, scan_c_q};
							first_q <= {scan_r_q, scan_c_q};
							last_q  <= {scan_r_q, scan_c_q};
							cnt_q   <= PW'(1);
							fwd_q   <= 1'b1;
							bidx_q  <= '1;
						end else begin
							scan_p_q <= scan_p_q + PW'(1);
							if ({1'b0, scan_c_q} + (CW+1)'(1) == cols_e) begin
								scan_c_q <= '0;
								scan_r_q <= scan_r_q + RW'(1);
							end else begin
								scan_c_q <= scan_c_q + CW'(1);
							end
						end
					end
					ST_WIN_INIT: begin
						yhi_q <= yhi_w;
						xlo_q <= xlo_w;
						xhi_q <= xhi_w;
						yy_q  <= ylo_w;
						xx_q  <= xlo_w;
						bv_q  <= 1'b0;
					end
					ST_WIN_CHK: begin
						// strict compare keeps the first hit in row-major order on a tie
						if (map_rdata && (!bv_q || d_w < best_d_q)) begin
							bv_q     <= 1'b1;
							best_d_q <= d_w;
							best_q   <= {yy_q, xx_q};
						end
						if (xx_q == xhi_q) begin
							xx_q <= xlo_q;
							yy_q <= yy_q + RW'(1);
						end else begin
							xx_q <= xx_q + CW'(1);
						end
					end
					ST_WIN_END: begin
						if (bv_q) begin
							cur_q <= best_q;
							cnt_q <= cnt_q + PW'(1);
							if (fwd_q) begin
								last_q <= best_q;
							end else begin
								first_q <= best_q;
								bidx_q  <= bidx_q - AW'(1);
							end
						end
					end
					ST_PHASE_END: begin
						if (fwd_q) begin
							fwd_q <= 1'b0;
							cur_q <= start_q;
						end
					end
					ST_KEEP: begin
						if (keep_w) begin
							curve_len_q   <= cnt_q;
							rd_pos_q      <= '0;
							base_q        <= bidx_q + AW'(1);
							curve_count_q <= curve_count_q + 16'd1;
							closed_q      <= closed_w;
						end
					end
					ST_OUT: begin
						if (out_free) begin
							out_x_q      <= 8'(cp_rdata[CW-1:0]);
							out_y_q      <= 8'(cp_rdata[AW-1:CW]);
							out_num_q    <= curve_count_q - 16'd1;
							out_last_q   <= (rd_pos_q + PW'(1)) == curve_len_q;
							out_closed_q <= closed_q;
							out_done_q   <= 1'b0;
							rd_pos_q     <= rd_pos_q + PW'(1);
						end
					end
					ST_OUT_DONE: begin
						if (out_free) begin
							out_x_q      <= '0;
							out_y_q      <= '0;
							out_num_q    <= '0;
							out_last_q   <= 1'b0;
							out_closed_q <= 1'b0;
							out_done_q   <= 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {7'd0, out_closed_q, out_num_q, out_y_q, out_x_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_done_q;

	`BECT_ASSERT_CLK(a_no_map_write_in_scan, (st_q == ST_WIN_RD || st_q == ST_WIN_CHK) |-> !map_we, "edge map written during window scan")
	`BECT_ASSERT_CLK(a_count_bound, cnt_q <= PW'(MAP_SIZE), "curve point count beyond map size")
	`BECT_ASSERT_CLK(a_read_bound, rd_pos_q <= curve_len_q, "read position past curve length")
	`BECT_ASSERT_CLK(a_done_clean, (m_valid_q && out_done_q) |-> (m_tdata == '0 && !m_tlast), "done word carries data")

endmodule

// File: tb/bect_curve_checker.sv
module bect_curve_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [bect_pkg::IDX_W-1:0] cfg_index,
	input  logic [bect_pkg::CFG_W-1:0] cfg_wdata,
	input  logic                       s_tvalid,
	input  logic                       s_tready,
	input  logic [7:0]                 s_tdata,   // [0] pixel
	input  logic                       s_tuser,   // [0] kind
	input  logic                       m_tvalid,
	input  logic                       m_tready,
	input  logic [39:0]                m_tdata,   // [7:0] pos_x, [15:8] pos_y,
	                                              // [31:16] curve_number, [32] closed_loop
	input  logic                       m_tlast,
	input  logic                       m_tuser,   // [0] done_res
	output int                         errors,
	output int                         outstanding,
	output int                         dones
);
	timeunit 1ns;
	timeprecision 1ps;
	import bect_pkg::*;

	typedef struct packed {
		logic [7:0]  pos_x;
		logic [7:0]  pos_y;
		logic [15:0] curve_no;
		logic        last;
		logic        closed;
		logic        done;
	} point_t;

	bit          pix_map [0:DEF_MAX_ROWS*DEF_MAX_COLS-1];
	int unsigned curve_pts [$];
	point_t      due_points [$];
	int unsigned rows_r, cols_r, gap_r;
	int unsigned load_pos, read_pos, curve_len, scan_from;
	logic [15:0] curves_kept;
	bit          curve_loop;

	function automatic int unsigned clamp(int unsigned v, int unsigned hi);
		return (v < 1) ? 1 : ((v > hi) ? hi : v);
	endfunction

	// nearest set pixel around (y,x) in the clipped window; clears it
	function automatic bit nearest(input int y, input int x, output int ny, output int nx);
		int g, nr, nc, best, yy, xx, d;
		g = clamp(gap_r, DEF_MAX_GAP);
		nr = clamp(rows_r, DEF_MAX_ROWS);
		nc = clamp(cols_r, DEF_MAX_COLS);
		best = -1;
		ny = 0;
		nx = 0;
		for (yy = y - g; yy <= y + g; yy++) begin
			if (yy < 0 || yy >= nr) continue;
			for (xx = x - g; xx <= x + g; xx++) begin
				if (xx < 0 || xx >= nc) continue;
				if (!pix_map[yy*DEF_MAX_COLS+xx]) continue;
				d = (yy - y) * (yy - y) + (xx - x) * (xx - x);
				if (best < 0 || d < best) begin
					best = d;
					ny = yy;
					nx = xx;
				end
			end
		end
		if (best < 0) return 1'b0;
		pix_map[ny*DEF_MAX_COLS+nx] = 1'b0;
		return 1'b1;
	endfunction

	function automatic bit find_seed(output int sy, output int sx);
		int unsigned nc, total, p;
		nc = clamp(cols_r, DEF_MAX_COLS);
		total = clamp(rows_r, DEF_MAX_ROWS) * nc;
		sy = 0;
		sx = 0;
		for (p = scan_from; p < total; p++) begin
			if (pix_map[(p / nc) * DEF_MAX_COLS + p % nc]) begin
				scan_from = p;
				sy = p / nc;
				sx = p % nc;
				return 1'b1;
			end
		end
		scan_from = total;
		return 1'b0;
	endfunction

	// forward trace, then backward trace prepended; true when the curve is kept
	function automatic bit link_curve(input int sy, input int sx);
		int y, x, ny, nx, dy, dx;
		pix_map[sy*DEF_MAX_COLS+sx] = 1'b0;
		curve_pts.delete();
		curve_pts.insert(curve_pts.size(), sy * DEF_MAX_COLS + sx);
		y = sy;
		x = sx;
		while (nearest(y, x, ny, nx)) begin
			curve_pts.insert(curve_pts.size(), ny * DEF_MAX_COLS + nx);
			y = ny;
			x = nx;
		end
		y = sy;
		x = sx;
		while (nearest(y, x, ny, nx)) begin
			curve_pts.push_front(ny * DEF_MAX_COLS + nx);
			y = ny;
			x = nx;
		end
		if (curve_pts.size() <=
		    (clamp(rows_r, DEF_MAX_ROWS) + clamp(cols_r, DEF_MAX_COLS)) / LEN_DIVISOR)
			return 1'b0;
		dy = int'(curve_pts[0] / DEF_MAX_COLS) - int'(curve_pts[$] / DEF_MAX_COLS);
		dx = int'(curve_pts[0] % DEF_MAX_COLS) - int'(curve_pts[$] % DEF_MAX_COLS);
		curve_loop = (dy * dy + dx * dx) <= CLOSE_LIMIT;
		curve_len = curve_pts.size();
		read_pos = 0;
		curves_kept = curves_kept + 16'd1;
		return 1'b1;
	endfunction

	function automatic void store_pixel(bit pix);
		int unsigned nc, total;
		nc = clamp(cols_r, DEF_MAX_COLS);
		total = clamp(rows_r, DEF_MAX_ROWS) * nc;
		if (load_pos < total) begin
			pix_map[(load_pos / nc) * DEF_MAX_COLS + load_pos % nc] = pix;
			if (pix && load_pos < scan_from) scan_from = load_pos;
			load_pos++;
		end
	endfunction

	function automatic void predict_pull();
		point_t pt;
		bit kept;
		int sy, sx;
		int unsigned p;
		pt = '0;
		if (read_pos >= curve_len) begin
			kept = 1'b0;
			while (!kept && find_seed(sy, sx)) kept = link_curve(sy, sx);
			if (!kept) begin
				read_pos = 0;
				curve_len = 0;
				pt.done = 1'b1;
				due_points.insert(due_points.size(), pt);
				return;
			end
		end
		p = curve_pts[read_pos];
		pt.pos_x = 8'(p % DEF_MAX_COLS);
		pt.pos_y = 8'(p / DEF_MAX_COLS);
		pt.curve_no = curves_kept - 16'd1;
		pt.last = (read_pos + 1 == curve_len);
		pt.closed = curve_loop;
		due_points.insert(due_points.size(), pt);
		read_pos++;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		point_t want, got;
		if (!arst_n) begin
			foreach (pix_map[i]) pix_map[i] = 1'b0;
			curve_pts.delete();
			due_points.delete();
			rows_r = DEF_MAX_ROWS;
			cols_r = DEF_MAX_COLS;
			gap_r = 1;
			load_pos = 0;
			read_pos = 0;
			curve_len = 0;
			scan_from = 0;
			curves_kept = '0;
			curve_loop = 1'b0;
			errors <= 0;
			outstanding <= 0;
			dones <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = {m_tdata[7:0], m_tdata[15:8], m_tdata[31:16], m_tlast, m_tdata[32],
				       m_tuser};
				if (got.done) dones <= dones + 1;
				if (due_points.size() == 0) begin
					$display("%0t: result word with nothing expected, got %p", $realtime, got);
					errors <= errors + 1;
				end else begin
					want = due_points.pop_front();
					if (got !== want) begin
						$display("%0t: result mismatch, expected %p, got %p",
						         $realtime, want, got);
						errors <= errors + 1;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_ROWS: begin rows_r = 32'(cfg_wdata); scan_from = 0; end
					REG_COLS: begin cols_r = 32'(cfg_wdata); scan_from = 0; end
					REG_GAP:  begin gap_r = 32'(cfg_wdata[2:0]); scan_from = 0; end
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser == KIND_LOAD) store_pixel(s_tdata[0]);
				else predict_pull();
			end
			outstanding <= due_points.size();
		end
	end

endmodule

// File: tb/tb_binary_edge_curve_tracer.sv
module tb_binary_edge_curve_tracer;
	timeunit 1ns;
	timeprecision 1ps;
	import bect_pkg::*;

	// unused register index: writes to it must change nothing
	localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;
	// cycles without any accepted word or register write before the run is called hung;
	// one pull may trace a whole 2x256 image at the widest window
	localparam int STALL_LIMIT = 600000;
	localparam int LONG_HOLD   = 700;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [7:0]       s_tdata = '0;      // [0] pixel
	logic             s_tuser = KIND_LOAD; // [0] kind
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [39:0]      m_tdata;           // [7:0] pos_x, [15:8] pos_y,
	                                     // [31:16] curve_number, [32] closed_loop
	logic             m_tlast;
	logic             m_tuser;           // [0] done_res

	int errors, outstanding, dones;
	int hold_asked = 0;
	int hold_given = 0;
	int sent = 0;
	bit send_calm = 1'b0;
	int quiet_cycles = 0;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	binary_edge_curve_tracer dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	bect_curve_checker chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.m_tuser(m_tuser),
		.errors(errors), .outstanding(outstanding), .dones(dones)
	);

	// Result side: random back-pressure per word, calm stretches now and then,
	// and one long hold-off on request so the block backs up into its input.
	always begin
		int stall;
		int taken;
		bit calm;
		taken = 0;
		calm = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_asked != hold_given) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				hold_given = hold_asked;
			end
			if (taken % 24 == 0) calm = ($urandom_range(0, 3) == 0);
			stall = calm ? 0 : $urandom_range(0, 11);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			taken++;
		end
	end

	// hang guard: any accepted word or register write restarts the count
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("[binary_edge_curve_tracer] ERROR");
			$finish;
		end
	end

	// one word on the input channel; called and returns at a falling edge
	task automatic send_word(logic kind, logic pix);
		int pause;
		if (sent % 32 == 0) send_calm = ($urandom_range(0, 3) == 0);
		pause = send_calm ? 0 : $urandom_range(0, 11);
		if (pause > 0) begin
			s_tvalid <= 1'b0;
			repeat (pause) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {7'b0, pix};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		sent++;
	endtask

	// only while idle: nothing owed and the block past any loads in flight
	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		s_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_pixels(int n, int density);
		repeat (n) send_word(KIND_LOAD, $urandom_range(0, 99) < density);
	endtask

	// pull until two more done markers have come back; stray loads mixed in
	// are past the image and must be ignored
	task automatic drain(bit noise);
		int target;
		target = dones + 2;
		while (dones < target) begin
			if (noise && $urandom_range(0, 7) == 0)
				send_word(KIND_LOAD, 1'($urandom_range(0, 1)));
			else
				send_word(KIND_PULL, 1'($urandom_range(0, 1)));
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Single-row strip at full width (511 clamps to 256, 0 rows acts as 1),
		// widest window; the spare index is written and must be ignored.
		write_reg(REG_ROWS, 9'd0);
		write_reg(REG_COLS, 9'd511);
		write_reg(REG_GAP, 9'd7);
		write_reg(REG_SPARE, 9'h1ff);
		// directed opening: a solid run long enough to keep, a gap, a short run
		repeat (14) send_word(KIND_LOAD, 1'b1);
		repeat (3) send_word(KIND_LOAD, 1'b0);
		repeat (4) send_word(KIND_LOAD, 1'b1);
		load_pixels(234, 45);
		send_word(KIND_LOAD, 1'b1);
		send_word(KIND_LOAD, 1'b1);   // one past the image: dropped
		drain(1'b0);

		// second row of the strip, gap 0 acting as 1; long hold on the result
		// side while pulls keep coming, then only part of the image is read out
		write_reg(REG_ROWS, 9'd2);
		write_reg(REG_GAP, 9'd0);
		load_pixels(256, 60);
		hold_asked++;
		repeat (40) send_word(KIND_PULL, 1'b0);
		repeat (60) send_word(KIND_PULL, 1'($urandom_range(0, 1)));

		// narrow window onto the left of what is left
		write_reg(REG_COLS, 9'd16);
		write_reg(REG_GAP, 9'd3);
		drain(1'b1);

		// smallest image: zero sizes act as one
		write_reg(REG_ROWS, 9'd1);
		write_reg(REG_COLS, 9'd0);
		write_reg(REG_GAP, 9'd5);
		drain(1'b1);

		// back to the whole strip and the widest window to finish it off
		write_reg(REG_ROWS, 9'd2);
		write_reg(REG_COLS, 9'd256);
		write_reg(REG_GAP, 9'd7);
		drain(1'b1);

		s_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		if (errors == 0 && outstanding == 0)
			$display("[binary_edge_curve_tracer] OK");
		else
			$display("[binary_edge_curve_tracer] ERROR");
		$finish;
	end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/bect_pkg.sv
hw/rtl/bect_ram.sv
hw/rtl/binary_edge_curve_tracer.sv
tb/bect_curve_checker.sv
tb/tb_binary_edge_curve_tracer.sv
